// ===== hdl/address_range_to_cidr_blocks_core_assert.svh =====
// Assertion macros shared by the address range to CIDR block logic.
`ifndef ADDRESS_RANGE_TO_CIDR_BLOCKS_CORE_ASSERT_SVH
`define ADDRESS_RANGE_TO_CIDR_BLOCKS_CORE_ASSERT_SVH

// same-cycle implication
`define ARCB_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("arcb check failed");

// next-cycle implication
`define ARCB_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("arcb check failed");

`endif

// ===== hdl/arcb_pkg.sv =====
// Shared types and constants of the address range to CIDR block logic.
package arcb_pkg;

   localparam int RAW_ADDR_W = 32;
   localparam int PREFIX_W   = 6;
   localparam int KIND_W     = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_SINGLE  = 2'd0,
      KIND_NETWORK = 2'd1,
      KIND_SPLIT   = 2'd2,
      KIND_INVALID = 2'd3
   } kind_type;

endpackage

// ===== hdl/arcb_fifo.sv =====
// Small register queue between the classifier and the block generator.
module arcb_fifo #(
   parameter int DATA_W = 66,
   parameter int DEPTH  = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              do_push;
   logic              do_pop;

   assign full     = cnt_ff == CNT_W'(DEPTH);
   assign empty    = cnt_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hdl/arcb_front.sv =====
// Input side: takes range beats, classifies them and queues them.
module arcb_front #(
   parameter int ADDR_BITS = 32
) (
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [arcb_pkg::RAW_ADDR_W-1:0]       req_range_start,
   input  logic [arcb_pkg::RAW_ADDR_W-1:0]       req_range_end,
   input  logic                                  q_full,
   output logic                                  q_push,
   output logic [2*ADDR_BITS+arcb_pkg::KIND_W-1:0] q_data
);

   logic [ADDR_BITS-1:0] start_a;
   logic [ADDR_BITS-1:0] stop_a;
   logic [ADDR_BITS-1:0] diff;
   logic [ADDR_BITS-1:0] diff_inc;
   logic                 is_network;
   arcb_pkg::kind_type   kind;

   for (genvar g = 0; g < ADDR_BITS; g++) begin : g_ext
      if (g < arcb_pkg::RAW_ADDR_W) begin : g_in
         assign start_a[g] = req_range_start[g];
         assign stop_a[g]  = req_range_end[g];
      end else begin : g_zero
         assign start_a[g] = 1'b0;
         assign stop_a[g]  = 1'b0;
      end
   end

   // one aligned block: differing bits form a low run of ones, clear in start
   assign diff       = start_a ^ stop_a;
   assign diff_inc   = diff + 1'b1;
   assign is_network = ((diff & diff_inc) == '0) && ((start_a & diff) == '0);

   always_comb begin
      if (start_a > stop_a) begin
         kind = arcb_pkg::KIND_INVALID;
      end else if (start_a == stop_a) begin
         kind = arcb_pkg::KIND_SINGLE;
      end else if (is_network) begin
         kind = arcb_pkg::KIND_NETWORK;
      end else begin
         kind = arcb_pkg::KIND_SPLIT;
      end
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign q_data    = {kind, start_a, stop_a};

endmodule

// ===== hdl/arcb_back.sv =====
// Output side: walks a queued range and emits one aligned block per beat.
`include "address_range_to_cidr_blocks_core_assert.svh"

module arcb_back #(
   parameter int ADDR_BITS = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    q_empty,
   input  logic [2*ADDR_BITS+arcb_pkg::KIND_W-1:0] q_data,
   output logic                                    q_pop,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [arcb_pkg::RAW_ADDR_W-1:0]         rsp_network_base,
   output logic [arcb_pkg::PREFIX_W-1:0]           rsp_prefix_length,
   output logic [arcb_pkg::KIND_W-1:0]             rsp_range_kind,
   output logic                                    rsp_last_block
);

   localparam int MAX_BLOCKS = 2 * ADDR_BITS - 2;
   localparam int CNT_W      = $clog2(MAX_BLOCKS);
   localparam int KW         = $clog2(ADDR_BITS + 1);
   localparam int SW         = $clog2(ADDR_BITS + 1);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type                       state_ff;
   logic [ADDR_BITS-1:0]            cur_ff;
   logic [ADDR_BITS-1:0]            stop_ff;
   arcb_pkg::kind_type              kind_ff;
   logic [CNT_W-1:0]                cnt_ff;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [arcb_pkg::RAW_ADDR_W-1:0] rsp_base_ff;
   logic [arcb_pkg::PREFIX_W-1:0]   rsp_prefix_ff;
   arcb_pkg::kind_type              rsp_kind_ff;
   logic                            rsp_last_ff;

   logic [ADDR_BITS:0]              rem;
   logic [ADDR_BITS:0]              smear;
   logic [ADDR_BITS-1:0]            size_mask;
   logic [ADDR_BITS-1:0]            align_mask;
   logic [ADDR_BITS-1:0]            span;
   logic [ADDR_BITS-1:0]            top;
   logic [ADDR_BITS-1:0]            cur_in;
   logic [KW-1:0]                   host_bits;
   logic [KW-1:0]                   pfx;
   logic [KW+arcb_pkg::PREFIX_W-1:0] pfx_wide;
   logic [arcb_pkg::RAW_ADDR_W-1:0] base_ext;
   logic                            done;
   logic                            adv;

   // largest block: limited by alignment of cur and by the remaining size
   assign rem = {1'b0, stop_ff} - {1'b0, cur_ff} + 1'b1;

   always_comb begin
      smear = rem;
      for (int j = 0; j < SW; j++) begin
         smear = smear | (smear >> (1 << j));
      end
   end

   assign size_mask  = smear[ADDR_BITS:1];
   assign align_mask = (cur_ff & (~cur_ff + 1'b1)) - 1'b1;
   assign span       = align_mask & size_mask;
   assign top        = cur_ff | span;
   assign cur_in     = top + 1'b1;

   always_comb begin
      host_bits = '0;
      for (int i = 0; i < ADDR_BITS; i++) begin
         if (span[i]) begin
            host_bits = KW'(i + 1);
         end
      end
   end

   assign pfx      = KW'(ADDR_BITS) - host_bits;
   assign pfx_wide = {{arcb_pkg::PREFIX_W{1'b0}}, pfx};

   for (genvar g = 0; g < arcb_pkg::RAW_ADDR_W; g++) begin : g_base
      if (g < ADDR_BITS) begin : g_in
         assign base_ext[g] = cur_ff[g];
      end else begin : g_zero
         assign base_ext[g] = 1'b0;
      end
   end

   assign done  = (top == stop_ff) || (cnt_ff == CNT_W'(MAX_BLOCKS - 1));
   assign adv   = !rsp_valid_ff || !rsp_stall;
   assign q_pop = (state_ff == ST_IDLE) && !q_empty;

   // new beat when the generator steps, else hold only while stalled
   assign rsp_valid_in = ((state_ff == ST_RUN) && adv) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  kind_ff  <= arcb_pkg::kind_type'(q_data[2*ADDR_BITS +: arcb_pkg::KIND_W]);
                  cur_ff   <= q_data[ADDR_BITS +: ADDR_BITS];
                  stop_ff  <= q_data[0 +: ADDR_BITS];
                  cnt_ff   <= '0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (adv) begin
                  rsp_kind_ff  <= kind_ff;
                  if (kind_ff == arcb_pkg::KIND_INVALID) begin
                     rsp_base_ff   <= '0;
                     rsp_prefix_ff <= '0;
                     rsp_last_ff   <= 1'b1;
                     state_ff      <= ST_IDLE;
                  end else begin
                     rsp_base_ff   <= base_ext;
                     rsp_prefix_ff <= pfx_wide[arcb_pkg::PREFIX_W-1:0];
                     rsp_last_ff   <= done;
                     if (done) begin
                        state_ff <= ST_IDLE;
                     end else begin
                        cur_ff <= cur_in;
                        cnt_ff <= cnt_ff + 1'b1;
                     end
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_network_base  = rsp_base_ff;
   assign rsp_prefix_length = rsp_prefix_ff;
   assign rsp_range_kind    = rsp_kind_ff;
   assign rsp_last_block    = rsp_last_ff;

   `ARCB_ASSERT_IMP(ast_invalid_shape, rsp_valid_ff && rsp_kind_ff == arcb_pkg::KIND_INVALID, rsp_last_ff && rsp_base_ff == '0 && rsp_prefix_ff == '0)
   `ARCB_ASSERT_IMP(ast_single_last, rsp_valid_ff && rsp_kind_ff == arcb_pkg::KIND_SINGLE, rsp_last_ff)
   `ARCB_ASSERT_IMP(ast_block_aligned, state_ff == ST_RUN && kind_ff != arcb_pkg::KIND_INVALID, (cur_ff & span) == '0 && top <= stop_ff)
   `ARCB_ASSERT_NXT(ast_mid_range, state_ff == ST_RUN && adv && kind_ff != arcb_pkg::KIND_INVALID && !done, rsp_valid_ff && !rsp_last_ff && state_ff == ST_RUN)

endmodule

// ===== hdl/address_range_to_cidr_blocks_core.sv =====
// Top level: inclusive address range in, run of aligned CIDR blocks out.
//
// Request channel (req_*): one beat carries an inclusive range, first and
// last address. A beat is taken when req_valid is high and req_stall low.
// Response channel (rsp_*): one beat per CIDR block, ascending, carrying
// base, prefix length and the range kind; rsp_last_block marks the final
// beat of a range. An invalid range (first above last) gives one beat of
// kind invalid with base and prefix zero.
// A classifier feeds a two-entry queue; the block generator behind it pops
// one range, loads it into its range registers and then emits one block per
// cycle through its output register while rsp_stall is low. A range gives at
// most 2*ADDR_BITS - 2 blocks (62 at the default width); its first beat passes
// the queue, the range registers and the output register, in that order.
// While rsp_stall is high the response beat holds and the generator waits;
// requests keep being taken until the queue fills, then req_stall rises.
// Reset (synchronous, active high) empties the queue and drops rsp_valid.
module address_range_to_cidr_blocks_core #(
   parameter int ADDR_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [arcb_pkg::RAW_ADDR_W-1:0]       req_range_start,
   input  logic [arcb_pkg::RAW_ADDR_W-1:0]       req_range_end,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [arcb_pkg::RAW_ADDR_W-1:0]       rsp_network_base,
   output logic [arcb_pkg::PREFIX_W-1:0]         rsp_prefix_length,
   output logic [arcb_pkg::KIND_W-1:0]           rsp_range_kind,
   output logic                                  rsp_last_block
);

   localparam int Q_W     = 2 * ADDR_BITS + arcb_pkg::KIND_W;
   localparam int Q_DEPTH = 2;

   logic           q_full;
   logic           q_push;
   logic [Q_W-1:0] q_wdata;
   logic           q_pop;
   logic [Q_W-1:0] q_rdata;
   logic           q_empty;

   arcb_front #(
      .ADDR_BITS (ADDR_BITS)
   ) u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_range_start (req_range_start),
      .req_range_end   (req_range_end),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_data          (q_wdata)
   );

   arcb_fifo #(
      .DATA_W (Q_W),
      .DEPTH  (Q_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   arcb_back #(
      .ADDR_BITS (ADDR_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_data            (q_rdata),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_network_base  (rsp_network_base),
      .rsp_prefix_length (rsp_prefix_length),
      .rsp_range_kind    (rsp_range_kind),
      .rsp_last_block    (rsp_last_block)
   );

endmodule
